@@ hw/rtl/nws_pkg.sv @@
// ----------------------------------------------------------------------------
// nws_pkg
// Shared constants and types of the Numerov wavefunction stepper: register
// indexes, result status codes and the digit size of the serial multiplier.
// ----------------------------------------------------------------------------
package nws_pkg;

    // Bits of the multiplier operand consumed per cycle.
    localparam int MUL_DIGIT = 8;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_LEVEL    = 3'd0,
        CFG_MASS_SCALE      = 3'd1,
        CFG_STEP_SQ_TWELFTH = 3'd2,
        CFG_START0_REAL     = 3'd3,
        CFG_START0_IMAG     = 3'd4,
        CFG_START1_REAL     = 3'd5,
        CFG_START1_IMAG     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SATURATED  = 2'd1,
        ST_COEF_ZERO  = 2'd2
    } t_status;

endpackage

@@ hw/rtl/nws_mul.sv @@
// ----------------------------------------------------------------------------
// nws_mul
// Unsigned serial multiplier. The second operand is consumed one digit per
// cycle, most significant digit first, into a shift-and-add accumulator.
// ----------------------------------------------------------------------------
module nws_mul
    import nws_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [VALUE_WIDTH-1:0]     i_a,
    input  logic [VALUE_WIDTH-1:0]     i_b,
    output logic                       o_done,
    output logic [2*VALUE_WIDTH-1:0]   o_prod
);

    localparam int W    = VALUE_WIDTH;
    localparam int NDIG = (W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BW   = NDIG * MUL_DIGIT;
    localparam int AW   = W + BW;
    localparam int CW   = $clog2(NDIG + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_cnt;
    logic [W-1:0]           r_a;
    logic [BW-1:0]          r_b;
    logic [AW-1:0]          r_acc;
    logic [W+MUL_DIGIT-1:0] part;

    assign part = r_a * r_b[BW-1 -: MUL_DIGIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // The product is complete once the last digit has been added.
            r_done <= r_busy && !i_start && (r_cnt == CW'(NDIG - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= BW'(i_b);
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= (r_acc << MUL_DIGIT) + AW'(part);
                r_b   <= r_b << MUL_DIGIT;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NDIG - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc[2*W-1:0];

endmodule

@@ hw/rtl/nws_div.sv @@
// ----------------------------------------------------------------------------
// nws_div
// Restoring divider for magnitudes. Divides (numerator << FRACTION_BITS) by
// the denominator one quotient bit per cycle, then rounds half away from zero.
// ----------------------------------------------------------------------------
module nws_div
    import nws_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [VALUE_WIDTH-1:0]                 i_num,
    input  logic [VALUE_WIDTH-1:0]                 i_den,
    output logic                                   o_done,
    output logic [VALUE_WIDTH+FRACTION_BITS:0]     o_quo
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int NB = W + F;
    localparam int CW = $clog2(NB + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND
    } t_dstate;

    t_dstate        r_state;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [NB-1:0]  r_num;
    logic [NB-1:0]  r_quo;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_den;
    logic [NB:0]    r_out;

    logic [W:0]     rem2;
    logic           fits;
    logic           round_up;

    assign rem2     = {r_rem, r_num[NB-1]};
    assign fits     = rem2 >= {1'b0, r_den};
    // Round up when the remainder is at least half the divisor.
    assign round_up = {r_rem, 1'b0} >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= (r_state == D_ROUND);
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= {i_num, {F{1'b0}}};
                        r_den   <= i_den;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= fits ? W'(rem2 - {1'b0, r_den}) : rem2[W-1:0];
                    r_quo <= {r_quo[NB-2:0], fits};
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(NB - 1)) begin
                        r_state <= D_ROUND;
                    end
                end
                D_ROUND: begin
                    r_out   <= {1'b0, r_quo} + (NB+1)'(round_up);
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_out;

endmodule

@@ hw/rtl/numerov_wavefunction_stepper_core.sv @@
// ----------------------------------------------------------------------------
// numerov_wavefunction_stepper_core
// Steps a complex wavefunction across a uniform grid with the Numerov
// recurrence, one potential sample per input word, in saturating fixed point.
// ----------------------------------------------------------------------------
// A start point goes to the output register by way of S_DONE; a recurrence point
// first takes ten products on the shared 8-bit-digit multiplier and, unless the
// leading coefficient is zero, two quotients on the one-bit-per-cycle divider.
// One word is in flight at a time; input stall is high until its result is registered.
// Synchronous active-low reset restores register defaults and begins a new sweep.
module numerov_wavefunction_stepper_core
    import nws_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_potential_sample,
    input  logic                          i_run_start,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_wave_real,
    output logic signed [VALUE_WIDTH-1:0] o_wave_imag,
    output logic [1:0]                    o_step_status,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [VALUE_WIDTH-1:0]        i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int PW = 2 * W + 1;
    localparam int MW = (2 * W + 1 > W + F + 1) ? 2 * W + 1 : W + F + 1;

    localparam logic [W-1:0]  VMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  VMIN     = {1'b1, {(W-1){1'b0}}};
    localparam bit            ONE_SAT  = (F >= W - 1);
    localparam bit            TWO_SAT  = (F + 1 >= W - 1);
    localparam bit            CONST_SAT = ONE_SAT || TWO_SAT;
    localparam logic [W-1:0]  ONE      = ONE_SAT ? VMAX : (W'(1) << F);
    localparam logic [W-1:0]  TWO      = TWO_SAT ? VMAX : (W'(2) << F);
    localparam logic [PW-1:0] RND_F    = PW'(1) << (F - 1);
    localparam logic [PW-1:0] RND_W    = PW'(1) << (W - 1);

    typedef struct packed {
        logic         sat;
        logic [W-1:0] val;
    } t_satval;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_COEF1,
        S_COEF2,
        S_NUM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    // Products in the order the sequencer issues them.
    typedef enum logic [3:0] {
        OP_K1,
        OP_Q1,
        OP_K0,
        OP_Q0,
        OP_KM,
        OP_QM,
        OP_PR_A,
        OP_PR_B,
        OP_PI_A,
        OP_PI_B
    } t_op;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    function automatic t_satval f_addsub(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic sub);
        logic [W:0] s;
        t_satval    r;
        s     = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        r.sat = s[W] ^ s[W-1];
        r.val = r.sat ? (s[W] ? VMIN : VMAX) : s[W-1:0];
        return r;
    endfunction

    // Clamp a magnitude to the signed range and apply the sign.
    function automatic t_satval f_sat_mag(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] limit;
        logic [MW-1:0] mm;
        logic [W-1:0]  mw;
        t_satval       r;
        limit = MW'(VMAX) + MW'(neg);
        r.sat = m > limit;
        mm    = r.sat ? limit : m;
        mw    = mm[W-1:0];
        r.val = neg ? (~mw + W'(1)) : mw;
        return r;
    endfunction

    // configuration registers
    logic [W-1:0] r_energy;
    logic [W-1:0] r_mass;
    logic [W-1:0] r_step_sq;
    logic [W-1:0] r_start0_re;
    logic [W-1:0] r_start0_im;
    logic [W-1:0] r_start1_re;
    logic [W-1:0] r_start1_im;

    // sweep history
    logic [1:0]   r_points;
    logic [W-1:0] r_pot_prev;
    logic [W-1:0] r_pot_prev2;
    logic [W-1:0] r_wave_prev_re;
    logic [W-1:0] r_wave_prev_im;
    logic [W-1:0] r_wave_prev2_re;
    logic [W-1:0] r_wave_prev2_im;

    // working registers
    t_state       r_state;
    t_op          r_op;
    logic         r_neg;
    logic         r_sat;
    logic         r_div_sel;
    logic [W-1:0] r_v;
    logic [W-1:0] r_k;
    logic [W-1:0] r_q1;
    logic [W-1:0] r_q0;
    logic [W-1:0] r_qm;
    logic [W-1:0] r_t10;
    logic [W-1:0] r_c1;
    logic [W-1:0] r_c2;
    logic [W-1:0] r_c3;
    logic [W-1:0] r_pa_re;
    logic [W-1:0] r_pb_re;
    logic [W-1:0] r_pa_im;
    logic [W-1:0] r_pb_im;
    logic [W-1:0] r_nr;
    logic [W-1:0] r_ni;
    logic [W-1:0] r_wr;
    logic [W-1:0] r_wi;
    t_status      r_status;

    // output register
    logic         r_o_valid;
    logic [W-1:0] r_o_real;
    logic [W-1:0] r_o_imag;
    t_status      r_o_status;

    // shared units
    logic             mul_done;
    logic [2*W-1:0]   mul_prod;
    logic             div_done;
    logic [W+F:0]     div_quo;

    logic [1:0]       pts_now;
    logic [W-1:0]     vsel;
    t_satval          ediff;
    logic [W-1:0]     mul_a;
    logic [W-1:0]     mul_b;
    logic             go_neg;
    logic             go_sat;
    logic             op_is_q;
    logic [PW-1:0]    mul_rnd;
    logic [MW-1:0]    mul_shifted;
    t_satval          mul_res;
    logic [W-1:0]     q0_mag;
    logic [W+3:0]     q0_x10;
    t_satval          c1_res;
    t_satval          c2_res;
    t_satval          c3_res;
    t_satval          t10_res;
    t_satval          nr_res;
    t_satval          ni_res;
    logic [W-1:0]     div_sel_num;
    logic [W-1:0]     div_num;
    logic [W-1:0]     div_den;
    logic             div_neg;
    t_satval          div_res;

    assign pts_now = i_run_start ? 2'd0 : r_points;

    // Operand selection for the multiplier at issue.
    always_comb begin
        vsel = r_v;
        case (r_op)
            OP_K0:   vsel = r_pot_prev;
            OP_KM:   vsel = r_pot_prev2;
            default: vsel = r_v;
        endcase
        ediff  = f_addsub(r_energy, vsel, 1'b1);
        mul_a  = '0;
        mul_b  = '0;
        go_neg = 1'b0;
        go_sat = 1'b0;
        case (r_op)
            OP_K1, OP_K0, OP_KM: begin
                mul_a  = f_mag(r_mass);
                mul_b  = f_mag(ediff.val);
                go_neg = r_mass[W-1] ^ ediff.val[W-1];
                go_sat = ediff.sat;
            end
            OP_Q1, OP_Q0, OP_QM: begin
                mul_a  = r_step_sq;
                mul_b  = f_mag(r_k);
                go_neg = r_k[W-1];
            end
            OP_PR_A: begin
                mul_a  = f_mag(r_c2);
                mul_b  = f_mag(r_wave_prev_re);
                go_neg = r_c2[W-1] ^ r_wave_prev_re[W-1];
            end
            OP_PR_B: begin
                mul_a  = f_mag(r_c3);
                mul_b  = f_mag(r_wave_prev2_re);
                go_neg = r_c3[W-1] ^ r_wave_prev2_re[W-1];
            end
            OP_PI_A: begin
                mul_a  = f_mag(r_c2);
                mul_b  = f_mag(r_wave_prev_im);
                go_neg = r_c2[W-1] ^ r_wave_prev_im[W-1];
            end
            OP_PI_B: begin
                mul_a  = f_mag(r_c3);
                mul_b  = f_mag(r_wave_prev2_im);
                go_neg = r_c3[W-1] ^ r_wave_prev2_im[W-1];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // The q products carry VALUE_WIDTH fraction bits in the step factor.
    assign op_is_q     = r_op inside {OP_Q1, OP_Q0, OP_QM};
    assign mul_rnd     = PW'(mul_prod) + (op_is_q ? RND_W : RND_F);
    assign mul_shifted = op_is_q ? MW'(mul_rnd >> W) : MW'(mul_rnd >> F);
    assign mul_res     = f_sat_mag(r_neg, mul_shifted);

    assign q0_mag  = f_mag(r_q0);
    assign q0_x10  = {1'b0, q0_mag, 3'b000} + {3'b000, q0_mag, 1'b0};
    assign t10_res = f_sat_mag(r_q0[W-1], MW'(q0_x10));
    assign c1_res  = f_addsub(ONE, r_q1, 1'b0);
    assign c3_res  = f_addsub(ONE, r_qm, 1'b0);
    assign c2_res  = f_addsub(TWO, r_t10, 1'b1);
    assign nr_res  = f_addsub(r_pa_re, r_pb_re, 1'b1);
    assign ni_res  = f_addsub(r_pa_im, r_pb_im, 1'b1);

    assign div_sel_num = r_div_sel ? r_ni : r_nr;
    assign div_num     = f_mag(div_sel_num);
    assign div_den     = f_mag(r_c1);
    assign div_neg     = div_sel_num[W-1] ^ r_c1[W-1];
    assign div_res     = f_sat_mag(r_neg, MW'(div_quo));

    nws_mul #(
        .VALUE_WIDTH (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MUL_GO),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    nws_div #(
        .VALUE_WIDTH   (W),
        .FRACTION_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy    <= '0;
            r_mass      <= ONE;
            r_step_sq   <= '0;
            r_start0_re <= ONE;
            r_start0_im <= '0;
            r_start1_re <= ONE;
            r_start1_im <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENERGY_LEVEL:    r_energy    <= i_cfg_data;
                CFG_MASS_SCALE:      r_mass      <= i_cfg_data;
                CFG_STEP_SQ_TWELFTH: r_step_sq   <= i_cfg_data;
                CFG_START0_REAL:     r_start0_re <= i_cfg_data;
                CFG_START0_IMAG:     r_start0_im <= i_cfg_data;
                CFG_START1_REAL:     r_start1_re <= i_cfg_data;
                CFG_START1_IMAG:     r_start1_im <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_op            <= OP_K1;
            r_points        <= 2'd0;
            r_o_valid       <= 1'b0;
            r_pot_prev      <= '0;
            r_pot_prev2     <= '0;
            r_wave_prev_re  <= '0;
            r_wave_prev_im  <= '0;
            r_wave_prev2_re <= '0;
            r_wave_prev2_im <= '0;
        end else begin
            // In S_DONE the output register is reloaded instead.
            if (r_o_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_v   <= i_potential_sample;
                        r_sat <= CONST_SAT;
                        if (pts_now == 2'd0) begin
                            r_wr     <= r_start0_re;
                            r_wi     <= r_start0_im;
                            r_status <= ST_OK;
                            r_points <= 2'd1;
                            r_state  <= S_DONE;
                        end else if (pts_now == 2'd1) begin
                            r_wr     <= r_start1_re;
                            r_wi     <= r_start1_im;
                            r_status <= ST_OK;
                            r_points <= 2'd2;
                            r_state  <= S_DONE;
                        end else begin
                            r_points <= 2'd2;
                            r_op     <= OP_K1;
                            r_state  <= S_MUL_GO;
                        end
                    end
                end
                S_MUL_GO: begin
                    r_neg   <= go_neg;
                    r_sat   <= r_sat | go_sat;
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (mul_done) begin
                        r_sat <= r_sat | mul_res.sat;
                        case (r_op)
                            OP_K1, OP_K0, OP_KM: r_k     <= mul_res.val;
                            OP_Q1:               r_q1    <= mul_res.val;
                            OP_Q0:               r_q0    <= mul_res.val;
                            OP_QM:               r_qm    <= mul_res.val;
                            OP_PR_A:             r_pa_re <= mul_res.val;
                            OP_PR_B:             r_pb_re <= mul_res.val;
                            OP_PI_A:             r_pa_im <= mul_res.val;
                            OP_PI_B:             r_pb_im <= mul_res.val;
                            default: begin
                            end
                        endcase
                        if (r_op == OP_QM) begin
                            r_state <= S_COEF1;
                        end else if (r_op == OP_PI_B) begin
                            r_state <= S_NUM;
                        end else begin
                            r_op    <= t_op'(r_op + 4'd1);
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_COEF1: begin
                    r_c1    <= c1_res.val;
                    r_c3    <= c3_res.val;
                    r_t10   <= t10_res.val;
                    r_sat   <= r_sat | c1_res.sat | c3_res.sat | t10_res.sat;
                    r_op    <= OP_PR_A;
                    r_state <= S_COEF2;
                end
                S_COEF2: begin
                    r_c2    <= c2_res.val;
                    r_sat   <= r_sat | c2_res.sat;
                    r_state <= S_MUL_GO;
                end
                S_NUM: begin
                    r_nr  <= nr_res.val;
                    r_ni  <= ni_res.val;
                    r_sat <= r_sat | nr_res.sat | ni_res.sat;
                    // A zero leading coefficient gives a zero point and no division.
                    if (r_c1 == '0) begin
                        r_wr     <= '0;
                        r_wi     <= '0;
                        r_status <= ST_COEF_ZERO;
                        r_state  <= S_DONE;
                    end else begin
                        r_div_sel <= 1'b0;
                        r_state   <= S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_neg   <= div_neg;
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (!r_div_sel) begin
                            r_wr      <= div_res.val;
                            r_sat     <= r_sat | div_res.sat;
                            r_div_sel <= 1'b1;
                            r_state   <= S_DIV_GO;
                        end else begin
                            r_wi     <= div_res.val;
                            r_status <= (r_sat | div_res.sat) ? ST_SATURATED : ST_OK;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid       <= 1'b1;
                        r_o_real        <= r_wr;
                        r_o_imag        <= r_wi;
                        r_o_status      <= r_status;
                        r_wave_prev2_re <= r_wave_prev_re;
                        r_wave_prev2_im <= r_wave_prev_im;
                        r_wave_prev_re  <= r_wr;
                        r_wave_prev_im  <= r_wi;
                        r_pot_prev2     <= r_pot_prev;
                        r_pot_prev      <= r_v;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_wave_real   = r_o_real;
    assign o_wave_imag   = r_o_imag;
    assign o_step_status = r_o_status;
    assign o_cfg_ready   = 1'b1;

endmodule

@@ hw/rtl/nws_checker.sv @@
// ----------------------------------------------------------------------------
// nws_checker
// Port-level checks on the Numerov wavefunction stepper, bound to its top
// level.
// ----------------------------------------------------------------------------
module nws_checker
    import nws_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [VALUE_WIDTH-1:0] o_wave_real,
    input logic [VALUE_WIDTH-1:0] o_wave_imag,
    input logic [1:0]             o_step_status
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_wave_real)
            && $stable(o_wave_imag) && $stable(o_step_status))
        else $error("result word changed while stalled");

    // Only one word is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted again straight after acceptance");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step_status == ST_OK) || (o_step_status == ST_SATURATED)
            || (o_step_status == ST_COEF_ZERO))
        else $error("undefined status code");

    a_zero_coef_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_step_status == ST_COEF_ZERO) |->
            (o_wave_real == '0) && (o_wave_imag == '0))
        else $error("zero leading coefficient with non-zero wavefunction");

endmodule

bind numerov_wavefunction_stepper_core nws_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_nws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_wave_real   (o_wave_real),
    .o_wave_imag   (o_wave_imag),
    .o_step_status (o_step_status)
);
